@@ design/tmi_pkg.sv @@
package tmi_pkg;

  localparam int PROGRAM_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF = 32768;
  localparam int STACK_DEPTH_DEF = 1024;

  localparam logic [7:0] CH_INC = 8'h2B;
  localparam logic [7:0] CH_DEC = 8'h2D;
  localparam logic [7:0] CH_LEFT = 8'h3C;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_OUT = 8'h2E;
  localparam logic [7:0] CH_IN = 8'h2C;
  localparam logic [7:0] CH_OPEN = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [2:0] OP_INC = 3'd0;
  localparam logic [2:0] OP_DEC = 3'd1;
  localparam logic [2:0] OP_LEFT = 3'd2;
  localparam logic [2:0] OP_RIGHT = 3'd3;
  localparam logic [2:0] OP_OUT = 3'd4;
  localparam logic [2:0] OP_IN = 3'd5;
  localparam logic [2:0] OP_OPEN = 3'd6;
  localparam logic [2:0] OP_CLOSE = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd1;
  localparam logic [2:0] ST_UNMATCHED_OPEN = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_LOADED = 3'd4;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  localparam int UAW = 4;

  localparam logic [UAW-1:0] U_CLEAR = 4'd0;
  localparam logic [UAW-1:0] U_IDLE = 4'd1;
  localparam logic [UAW-1:0] U_LOAD = 4'd2;
  localparam logic [UAW-1:0] U_END = 4'd3;
  localparam logic [UAW-1:0] U_STEP = 4'd4;
  localparam logic [UAW-1:0] U_NONE = 4'd5;
  localparam logic [UAW-1:0] U_STORE = 4'd6;
  localparam logic [UAW-1:0] U_MATE = 4'd7;
  localparam logic [UAW-1:0] U_EXEC = 4'd8;
  localparam logic [UAW-1:0] U_CELL = 4'd9;
  localparam logic [UAW-1:0] U_RESP = 4'd10;

  localparam logic [3:0] ACT_NOP = 4'd0;
  localparam logic [3:0] ACT_CLEAR = 4'd1;
  localparam logic [3:0] ACT_WAIT = 4'd2;
  localparam logic [3:0] ACT_LOAD_CHECK = 4'd3;
  localparam logic [3:0] ACT_LOAD_STORE = 4'd4;
  localparam logic [3:0] ACT_LOAD_MATE = 4'd5;
  localparam logic [3:0] ACT_END = 4'd6;
  localparam logic [3:0] ACT_FETCH = 4'd7;
  localparam logic [3:0] ACT_EXEC = 4'd8;
  localparam logic [3:0] ACT_CELL = 4'd9;
  localparam logic [3:0] ACT_RESP = 4'd10;

  localparam logic [2:0] COND_ALWAYS = 3'd0;
  localparam logic [2:0] COND_CLR_DONE = 3'd1;
  localparam logic [2:0] COND_DISPATCH = 3'd2;
  localparam logic [2:0] COND_LOAD_SKIP = 3'd3;
  localparam logic [2:0] COND_NOT_CLOSE = 3'd4;
  localparam logic [2:0] COND_STEP_IDLE = 3'd5;
  localparam logic [2:0] COND_MOVE = 3'd6;
  localparam logic [2:0] COND_RSP_FREE = 3'd7;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] cond;
    logic [UAW-1:0] t_true;
    logic [UAW-1:0] t_false;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic [1:0] kind;
    logic clr_done;
    logic load_skip;
    logic not_close;
    logic step_idle;
    logic move;
    logic rsp_free;
  } flags_t;

  typedef struct packed {
    logic cmd;
    logic [2:0] op;
  } cmd_t;

  function automatic cmd_t decode_char(input logic [7:0] c);
    cmd_t d;
    d.cmd = 1'b1;
    d.op = OP_INC;
    case (c)
      CH_INC: d.op = OP_INC;
      CH_DEC: d.op = OP_DEC;
      CH_LEFT: d.op = OP_LEFT;
      CH_RIGHT: d.op = OP_RIGHT;
      CH_OUT: d.op = OP_OUT;
      CH_IN: d.op = OP_IN;
      CH_OPEN: d.op = OP_OPEN;
      CH_CLOSE: d.op = OP_CLOSE;
      default: d.cmd = 1'b0;
    endcase
    return d;
  endfunction

  // The dispatch step jumps to U_LOAD plus the item kind.
  function automatic ucode_t ucode_rom(input logic [UAW-1:0] a);
    ucode_t w;
    unique case (a)
      U_CLEAR: w = '{ACT_CLEAR, COND_CLR_DONE, U_IDLE, U_CLEAR};
      U_IDLE: w = '{ACT_WAIT, COND_DISPATCH, U_LOAD, U_IDLE};
      U_LOAD: w = '{ACT_LOAD_CHECK, COND_LOAD_SKIP, U_RESP, U_STORE};
      U_END: w = '{ACT_END, COND_ALWAYS, U_RESP, U_RESP};
      U_STEP: w = '{ACT_FETCH, COND_STEP_IDLE, U_RESP, U_EXEC};
      U_NONE: w = '{ACT_NOP, COND_ALWAYS, U_RESP, U_RESP};
      U_STORE: w = '{ACT_LOAD_STORE, COND_NOT_CLOSE, U_RESP, U_MATE};
      U_MATE: w = '{ACT_LOAD_MATE, COND_ALWAYS, U_RESP, U_RESP};
      U_EXEC: w = '{ACT_EXEC, COND_MOVE, U_CELL, U_RESP};
      U_CELL: w = '{ACT_CELL, COND_ALWAYS, U_RESP, U_RESP};
      U_RESP: w = '{ACT_RESP, COND_RSP_FREE, U_IDLE, U_RESP};
      default: w = '{ACT_NOP, COND_ALWAYS, U_IDLE, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/tmi_useq.sv @@
module tmi_useq (
  input  logic clk,
  input  logic rst,
  input  tmi_pkg::flags_t flags,
  output tmi_pkg::ucode_t ctrl
);

  logic [tmi_pkg::UAW-1:0] upc;
  logic [tmi_pkg::UAW-1:0] upc_next;
  logic taken;

  assign ctrl = tmi_pkg::ucode_rom(upc);

  always_comb begin
    taken = 1'b1;
    unique case (ctrl.cond)
      tmi_pkg::COND_ALWAYS: taken = 1'b1;
      tmi_pkg::COND_CLR_DONE: taken = flags.clr_done;
      tmi_pkg::COND_DISPATCH: taken = flags.accept;
      tmi_pkg::COND_LOAD_SKIP: taken = flags.load_skip;
      tmi_pkg::COND_NOT_CLOSE: taken = flags.not_close;
      tmi_pkg::COND_STEP_IDLE: taken = flags.step_idle;
      tmi_pkg::COND_MOVE: taken = flags.move;
      tmi_pkg::COND_RSP_FREE: taken = flags.rsp_free;
      default: taken = 1'b1;
    endcase
    if (!taken) begin
      upc_next = ctrl.t_false;
    end else if (ctrl.cond == tmi_pkg::COND_DISPATCH) begin
      upc_next = ctrl.t_true + {2'b00, flags.kind};
    end else begin
      upc_next = ctrl.t_true;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= tmi_pkg::U_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  a_upc_range: assert property (@(posedge clk) disable iff (rst) upc <= tmi_pkg::U_RESP)
    else $error("Microcode address left the program.");

  a_wait_at_idle: assert property (@(posedge clk) disable iff (rst)
    flags.accept |=> $past(upc) == tmi_pkg::U_IDLE && upc != tmi_pkg::U_IDLE)
    else $error("An item was taken outside the idle step.");

  a_resp_to_idle: assert property (@(posedge clk) disable iff (rst)
    upc == tmi_pkg::U_RESP && flags.rsp_free |=> upc == tmi_pkg::U_IDLE)
    else $error("Result step did not return to idle.");

endmodule

@@ design/tmi_datapath.sv @@
module tmi_datapath #(
  parameter int PROGRAM_DEPTH = tmi_pkg::PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH = tmi_pkg::TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH = tmi_pkg::STACK_DEPTH_DEF,
  localparam int PW = $clog2(PROGRAM_DEPTH),
  localparam int TW = $clog2(TAPE_DEPTH),
  localparam int SW = $clog2(STACK_DEPTH)
) (
  input  logic clk,
  input  logic rst,
  input  tmi_pkg::ucode_t ctrl,
  output tmi_pkg::flags_t flags,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  logic [1:0] kind,
  input  logic [7:0] byte_in,
  output logic rsp_valid,
  input  logic rsp_stall,
  output logic [2:0] status,
  output logic out_valid,
  output logic [7:0] out_byte,
  output logic left_loop,
  output logic halted,
  output logic [PW:0] pc_now,
  output logic [TW-1:0] cell_index,
  output logic [7:0] cell_value
);

  localparam logic [PW:0] LEN_FULL = (PW+1)'(PROGRAM_DEPTH);
  localparam logic [SW:0] TOP_FULL = (SW+1)'(STACK_DEPTH);
  localparam logic [TW-1:0] TP_LAST = TW'(TAPE_DEPTH - 1);

  logic [2:0] prog [PROGRAM_DEPTH];
  logic [PW-1:0] jt [PROGRAM_DEPTH];
  logic [PW-1:0] stack [STACK_DEPTH];
  logic [7:0] tape [TAPE_DEPTH];

  logic [2:0] prog_q;
  logic [PW-1:0] jt_q;
  logic [PW-1:0] stack_q;
  logic [7:0] tape_q;

  logic [PW:0] len;
  logic [PW:0] pc;
  logic [TW-1:0] tp;
  logic [SW:0] top;
  logic load_done;
  logic [7:0] cur_cell;
  logic [TW-1:0] clr;

  logic [7:0] byte_r;
  logic [2:0] status_r;
  logic emit_r;
  logic [7:0] emit_byte_r;
  logic left_r;

  logic accept;
  logic rsp_free;
  tmi_pkg::cmd_t cmd;
  logic [2:0] load_status;
  logic load_skip;
  logic is_move;
  logic [TW-1:0] tp_left;
  logic [TW-1:0] tp_right;
  logic [TW-1:0] tp_next;
  logic [TW-1:0] tape_raddr;
  logic [SW-1:0] stack_raddr;
  logic [7:0] cell_exec;
  logic cell_write;
  logic [PW:0] pc_base;
  logic leave;
  logic emit;
  logic jt_we;
  logic [PW-1:0] jt_waddr;
  logic [PW-1:0] jt_wdata;

  assign cmd_stall = ctrl.act != tmi_pkg::ACT_WAIT;
  assign accept = cmd_valid && !cmd_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign cmd = tmi_pkg::decode_char(byte_r);

  assign tp_left = (tp == '0) ? TP_LAST : tp - TW'(1);
  assign tp_right = (tp == TP_LAST) ? '0 : tp + TW'(1);
  assign tp_next = (prog_q == tmi_pkg::OP_LEFT) ? tp_left : tp_right;
  assign is_move = prog_q == tmi_pkg::OP_LEFT || prog_q == tmi_pkg::OP_RIGHT;
  assign tape_raddr = (ctrl.act == tmi_pkg::ACT_EXEC) ? tp_next : tp;
  assign stack_raddr = SW'(top - (SW+1)'(1));

  always_comb begin
    load_status = tmi_pkg::ST_OK;
    load_skip = 1'b1;
    if (!load_done && cmd.cmd) begin
      if (len == LEN_FULL) begin
        load_status = tmi_pkg::ST_FULL;
      end else if (cmd.op == tmi_pkg::OP_OPEN && top == TOP_FULL) begin
        load_status = tmi_pkg::ST_FULL;
      end else if (cmd.op == tmi_pkg::OP_CLOSE && top == '0) begin
        load_status = tmi_pkg::ST_UNMATCHED_CLOSE;
      end else begin
        load_skip = 1'b0;
      end
    end
  end

  always_comb begin
    cell_exec = cur_cell;
    cell_write = 1'b0;
    pc_base = pc;
    leave = 1'b0;
    emit = 1'b0;
    case (prog_q)
      tmi_pkg::OP_INC: begin
        cell_exec = cur_cell + 8'd1;
        cell_write = 1'b1;
      end
      tmi_pkg::OP_DEC: begin
        cell_exec = cur_cell - 8'd1;
        cell_write = 1'b1;
      end
      tmi_pkg::OP_IN: begin
        cell_exec = byte_r;
        cell_write = 1'b1;
      end
      tmi_pkg::OP_OUT: emit = 1'b1;
      tmi_pkg::OP_OPEN: begin
        if (cur_cell == 8'd0) begin
          pc_base = {1'b0, jt_q};
          leave = 1'b1;
        end
      end
      tmi_pkg::OP_CLOSE: begin
        if (cur_cell != 8'd0) begin
          pc_base = {1'b0, jt_q};
        end else begin
          leave = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    jt_we = 1'b0;
    jt_waddr = len[PW-1:0];
    jt_wdata = stack_q;
    if (ctrl.act == tmi_pkg::ACT_LOAD_STORE && cmd.op == tmi_pkg::OP_CLOSE) begin
      jt_we = 1'b1;
    end else if (ctrl.act == tmi_pkg::ACT_LOAD_MATE) begin
      jt_we = 1'b1;
      jt_waddr = stack_q;
      jt_wdata = len[PW-1:0];
    end
  end

  always_comb begin
    flags.accept = accept;
    flags.kind = kind;
    flags.clr_done = clr == TP_LAST;
    flags.load_skip = load_skip;
    flags.not_close = cmd.op != tmi_pkg::OP_CLOSE;
    flags.step_idle = !load_done || pc >= len;
    flags.move = is_move;
    flags.rsp_free = rsp_free;
  end

  always_ff @(posedge clk) begin
    prog_q <= prog[pc[PW-1:0]];
    jt_q <= jt[pc[PW-1:0]];
    stack_q <= stack[stack_raddr];
    tape_q <= tape[tape_raddr];
    if (ctrl.act == tmi_pkg::ACT_LOAD_STORE) begin
      prog[len[PW-1:0]] <= cmd.op;
    end
    if (ctrl.act == tmi_pkg::ACT_LOAD_STORE && cmd.op == tmi_pkg::OP_OPEN) begin
      stack[top[SW-1:0]] <= len[PW-1:0];
    end
    if (jt_we) begin
      jt[jt_waddr] <= jt_wdata;
    end
    if (ctrl.act == tmi_pkg::ACT_CLEAR) begin
      tape[clr] <= 8'd0;
    end else if (ctrl.act == tmi_pkg::ACT_EXEC && cell_write) begin
      tape[tp] <= cell_exec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      pc <= '0;
      tp <= '0;
      top <= '0;
      load_done <= 1'b0;
      cur_cell <= 8'd0;
      clr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.act == tmi_pkg::ACT_CLEAR) begin
        clr <= clr + TW'(1);
      end
      if (ctrl.act == tmi_pkg::ACT_LOAD_STORE) begin
        if (cmd.op == tmi_pkg::OP_OPEN) begin
          top <= top + (SW+1)'(1);
        end else if (cmd.op == tmi_pkg::OP_CLOSE) begin
          top <= top - (SW+1)'(1);
        end
        if (cmd.op != tmi_pkg::OP_CLOSE) begin
          len <= len + (PW+1)'(1);
        end
      end
      if (ctrl.act == tmi_pkg::ACT_LOAD_MATE) begin
        len <= len + (PW+1)'(1);
      end
      if (ctrl.act == tmi_pkg::ACT_END && top == '0) begin
        load_done <= 1'b1;
      end
      if (ctrl.act == tmi_pkg::ACT_EXEC) begin
        pc <= pc_base + (PW+1)'(1);
        cur_cell <= cell_exec;
        if (is_move) begin
          tp <= tp_next;
        end
      end
      if (ctrl.act == tmi_pkg::ACT_CELL) begin
        cur_cell <= tape_q;
      end
      if (ctrl.act == tmi_pkg::ACT_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= byte_in;
      status_r <= tmi_pkg::ST_OK;
      emit_r <= 1'b0;
      emit_byte_r <= 8'd0;
      left_r <= 1'b0;
    end
    if (ctrl.act == tmi_pkg::ACT_LOAD_CHECK) begin
      status_r <= load_status;
    end
    if (ctrl.act == tmi_pkg::ACT_END && !load_done && top != '0) begin
      status_r <= tmi_pkg::ST_UNMATCHED_OPEN;
    end
    if (ctrl.act == tmi_pkg::ACT_FETCH && !load_done) begin
      status_r <= tmi_pkg::ST_NOT_LOADED;
    end
    if (ctrl.act == tmi_pkg::ACT_EXEC) begin
      emit_r <= emit;
      emit_byte_r <= emit ? cur_cell : 8'd0;
      left_r <= leave;
    end
    if (ctrl.act == tmi_pkg::ACT_RESP && rsp_free) begin
      status <= status_r;
      out_valid <= emit_r;
      out_byte <= emit_byte_r;
      left_loop <= left_r;
      halted <= load_done && pc >= len;
      pc_now <= pc;
      cell_index <= tp;
      cell_value <= cur_cell;
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst) top <= TOP_FULL)
    else $error("Bracket stack pointer ran past its depth.");

  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= LEN_FULL)
    else $error("Program length ran past its depth.");

  a_pc_bound: assert property (@(posedge clk) disable iff (rst) pc <= len)
    else $error("Program counter ran past the program length.");

  a_loaded_balanced: assert property (@(posedge clk) disable iff (rst) load_done |-> top == '0)
    else $error("Execution armed with open brackets.");

endmodule

@@ design/tape_machine_interpreter.sv @@
// Brainfuck-style tape machine interpreter.
// Items arrive on the cmd channel (kind, byte_in) and one result per item
// leaves on the rsp channel; both use valid and stall.
// Kind 0 loads one program character, kind 1 ends a balanced load and arms
// execution, kind 2 runs one instruction, and the read command takes byte_in.
// A small microprogram sequences a datapath around four synchronous memories:
// program store, jump table, bracket stack and tape.
// Each item passes from the idle step through steps chosen by its kind to
// the result step. A character is checked and, unless dropped, stored; a
// closing bracket adds a step that writes its mate's jump table entry. A
// step item fetches, executes if one is due, and after a pointer move reads
// the new tape cell. The tape cell read after a pointer move and the single
// jump table write port set these extra steps. One item is in flight at a
// time, and the next is taken in the idle step after the result loads.
// After reset the tape is cleared one cell per cycle, from cell 0 to cell
// TAPE_DEPTH-1, and cmd_stall stays high until that pass ends.
// The result sits in an output register; while rsp_stall is high it holds,
// and the block finishes its item and waits before taking the next one.
module tape_machine_interpreter #(
  parameter int PROGRAM_DEPTH = tmi_pkg::PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH = tmi_pkg::TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH = tmi_pkg::STACK_DEPTH_DEF,
  localparam int PW = $clog2(PROGRAM_DEPTH),
  localparam int TW = $clog2(TAPE_DEPTH)
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  logic [1:0] kind,
  input  logic [7:0] byte_in,
  output logic rsp_valid,
  input  logic rsp_stall,
  output logic [2:0] status,
  output logic out_valid,
  output logic [7:0] out_byte,
  output logic left_loop,
  output logic halted,
  output logic [PW:0] pc_now,
  output logic [TW-1:0] cell_index,
  output logic [7:0] cell_value
);

  tmi_pkg::ucode_t ctrl;
  tmi_pkg::flags_t flags;

  tmi_useq u_useq (
    .clk(clk),
    .rst(rst),
    .flags(flags),
    .ctrl(ctrl)
  );

  tmi_datapath #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .TAPE_DEPTH(TAPE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .flags(flags),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .kind(kind),
    .byte_in(byte_in),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .out_valid(out_valid),
    .out_byte(out_byte),
    .left_loop(left_loop),
    .halted(halted),
    .pc_now(pc_now),
    .cell_index(cell_index),
    .cell_value(cell_value)
  );

endmodule
